// ===== hdl/rmc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the range-masked CRC block.
// No dependencies.
`default_nettype none

package rmc_pkg;

  localparam int SLOT_W = 9;
  localparam int CNT_W  = 10;
  localparam int POS_W  = 32;
  localparam int END_W  = 33;
  localparam int ADDR_W = 4;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DATA = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_EXPECTED = 2'd0,
    REG_COUNT    = 2'd1,
    REG_IGN_EN   = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  // Request traveling down the range-cell chain. For a load request, a is the range
  // start and b the 33-bit range end. For a data request, a is the byte position.
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  a;
    logic [END_W-1:0]  b;
    logic              ign;
    logic [7:0]        data;
    logic              last;
    logic              hit;
  } token_t;

  typedef struct packed {
    logic             adv;
    logic [CNT_W-1:0] count;
    logic             ign_en;
  } ctl_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/range_masked_crc32.sv =====
// Top level: config registers, input stage, range-cell chain and CRC tail.
// Depends on rmc_pkg, rmc_cell, rmc_crc.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_kind .. in_last_byte                 | in_valid / in_stall
//  result  | out_crc_value, out_crc_matches          | out_valid / out_stall
//  config  | cfg_psel/penable/pwrite/paddr/pwdata    | APB, cfg_pready tied high
//
// One request accepted per cycle while in_stall is low; each passes RANGE_SLOTS cells
// in order. A result is registered at the tail after its last byte has passed the input
// register and the range-cell chain. The whole chain holds only while a final byte
// waits at the tail behind a stalled result. Synchronous active-low reset clears position
// and all valid flags and presets the CRC; table contents are undefined until loaded.
`default_nettype none

module range_masked_crc32
  import rmc_pkg::*;
#(
  parameter int RANGE_SLOTS = 512
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [31:0]       in_range_first,
  input  wire logic [31:0]       in_range_bytes,
  input  wire logic              in_range_is_ignore,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_crc_value,
  output logic                   out_crc_matches,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [31:0]      expected_r;
  logic [CNT_W-1:0] count_r;
  logic             ign_en_r;
  logic [POS_W-1:0] pos_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  logic             adv;
  logic             accept;
  token_t           tok_new;
  token_t           tok_in_r;
  token_t           chain [RANGE_SLOTS+1];
  ctl_t             ctl;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      count_r    <= '0;
      ign_en_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_EXPECTED: expected_r <= cfg_pwdata;
        REG_COUNT:    count_r    <= cfg_pwdata[CNT_W-1:0];
        REG_IGN_EN:   ign_en_r   <= cfg_pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXPECTED: cfg_prdata = expected_r;
      REG_COUNT:    cfg_prdata = {{(32-CNT_W){1'b0}}, count_r};
      REG_IGN_EN:   cfg_prdata = {31'd0, ign_en_r};
      default:      cfg_prdata = '0;
    endcase
  end

  assign adv = !(chain[RANGE_SLOTS].valid && chain[RANGE_SLOTS].kind == KIND_DATA &&
                 chain[RANGE_SLOTS].last && out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    tok_new.valid = in_valid;
    tok_new.kind  = kind_t'(in_kind);
    tok_new.slot  = in_slot;
    tok_new.a     = (in_kind == KIND_DATA) ? pos_r : in_range_first;
    tok_new.b     = {1'b0, in_range_first} + {1'b0, in_range_bytes};
    tok_new.ign   = in_range_is_ignore;
    tok_new.data  = in_data_byte;
    tok_new.last  = in_last_byte;
    tok_new.hit   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      tok_in_r.valid <= 1'b0;
    end else if (adv) begin
      tok_in_r <= tok_new;
      if (accept && in_kind == KIND_DATA) begin
        pos_r <= in_last_byte ? '0 : pos_r + POS_W'(1);
      end
    end
  end

  assign ctl.adv    = adv;
  assign ctl.count  = count_r;
  assign ctl.ign_en = ign_en_r;

  assign chain[0] = tok_in_r;

  for (genvar i = 0; i < RANGE_SLOTS; i++) begin : g_cell
    rmc_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  rmc_crc u_crc (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .tok            (chain[RANGE_SLOTS]),
    .expected       (expected_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_crc_value  (out_crc_value),
    .out_crc_matches(out_crc_matches)
  );

endmodule

`default_nettype wire

// ===== hdl/rmc_cell.sv =====
// One range cell: holds one table slot and passes the request to the next cell.
// Depends on rmc_pkg.
`default_nettype none

module rmc_cell
  import rmc_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ctl_t   ctl,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  logic [POS_W-1:0] first_r;
  logic [END_W-1:0] end_r;
  logic             ign_r;
  token_t           tok_r;
  token_t           tok_nxt;
  logic             active;
  logic             in_range;
  logic             slot_hit;

  assign slot_hit = ({1'b0, tok_in.slot} == CNT_W'(CELL_IDX));
  assign active   = (CNT_W'(CELL_IDX) < ctl.count) && (!ign_r || ctl.ign_en);
  assign in_range = (tok_in.a >= first_r) && ({1'b0, tok_in.a} < end_r);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.kind == KIND_DATA && active && in_range) begin
      tok_nxt.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && tok_in.valid && tok_in.kind == KIND_LOAD && slot_hit) begin
      first_r <= tok_in.a;
      end_r   <= tok_in.b;
      ign_r   <= tok_in.ign;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (ctl.adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== hdl/rmc_crc.sv =====
// CRC-32 byte engine and result register at the tail of the range-cell chain.
// Depends on rmc_pkg.
`default_nettype none

module rmc_crc
  import rmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire token_t      tok,
  input  wire logic [31:0] expected,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [31:0]      out_crc_value,
  output logic             out_crc_matches
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic        valid_r;
  logic [31:0] value_r;
  logic        match_r;
  logic [7:0]  eff_byte;
  logic        take;

  assign eff_byte = tok.hit ? 8'd0 : tok.data;
  assign crc_nxt  = crc_step(crc_r, eff_byte);
  assign take     = adv && tok.valid && tok.kind == KIND_DATA;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_PRESET;
      valid_r <= 1'b0;
    end else begin
      if (take && tok.last) begin
        crc_r   <= CRC_PRESET;
        valid_r <= 1'b1;
        value_r <= ~crc_nxt;
        match_r <= (~crc_nxt == expected);
      end else begin
        if (take) begin
          crc_r <= crc_nxt;
        end
        if (valid_r && !out_stall) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_crc_value   = value_r;
  assign out_crc_matches = match_r;

endmodule

`default_nettype wire

// ===== hdl/rmc_check.sv =====
// Port-level checks for range_masked_crc32, attached by bind.
// Depends on rmc_pkg and range_masked_crc32.
`default_nettype none

module rmc_check
  import rmc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_crc_value,
  input wire logic        out_crc_matches,
  input wire logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_crc_value) && $stable(out_crc_matches))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("config port not ready");

endmodule

bind range_masked_crc32 rmc_check u_rmc_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_crc_value  (out_crc_value),
  .out_crc_matches(out_crc_matches),
  .cfg_pready     (cfg_pready)
);

`default_nettype wire

// ===== sim/tb_range_masked_crc32.sv =====
// Self-checking testbench for range_masked_crc32: random requests, random stalls,
// register writes over the config port, and an in-bench CRC-32 predictor.
// Depends on rmc_pkg and range_masked_crc32 (hdl/).
module tb_range_masked_crc32;
  import rmc_pkg::*;

  localparam int RANGE_SLOTS = 512;
  localparam int CLK_PERIOD  = 12;
  localparam int DRAIN       = RANGE_SLOTS + 8;
  localparam int LONG_HOLD   = 1500;
  localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;

  typedef struct {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       first;
    logic [31:0]       len;
    logic              ign;
    logic [7:0]        data;
    logic              last;
  } req_t;

  typedef struct {
    logic [31:0] crc;
    logic        match;
  } crc_res_t;

  logic clk = 1'b1;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = 1'b0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [31:0]       in_range_first = '0;
  logic [31:0]       in_range_bytes = '0;
  logic              in_range_is_ignore = 1'b0;
  logic [7:0]        in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       out_crc_value;
  logic              out_crc_matches;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // stimulus and scoreboard
  req_t      req_queue[$];
  crc_res_t  pending_crcs[$];
  logic [7:0] last_file[$];
  bit        slot_written[RANGE_SLOTS];
  int        n_offered = 0;
  int        n_accepted = 0;
  int        send_gap = 0;
  int        stall_gap = 0;
  int        hold_orders = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  bit        calm = 1'b0;
  int        err_count = 0;

  // predictor state
  logic [31:0]      zr_first[RANGE_SLOTS];
  logic [31:0]      zr_len[RANGE_SLOTS];
  logic             zr_ign[RANGE_SLOTS];
  logic [31:0]      file_pos;
  logic [31:0]      crc_acc;
  logic [31:0]      m_expected;
  logic [CNT_W-1:0] m_count;
  logic             m_ign_en;
  logic [31:0]      last_crc;

  range_masked_crc32 #(.RANGE_SLOTS(RANGE_SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_slot(in_slot),
    .in_range_first(in_range_first), .in_range_bytes(in_range_bytes),
    .in_range_is_ignore(in_range_is_ignore),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_crc_value(out_crc_value), .out_crc_matches(out_crc_matches),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #(CLK_PERIOD / 2);
    clk = 1'b0;
    #(CLK_PERIOD / 2);
  end

  function automatic logic [31:0] crc32_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CRC32_POLY;
    end
    return c;
  endfunction

  // union of all active ranges, 33-bit end
  function automatic bit pos_zeroed(input logic [31:0] p);
    int          n;
    logic [32:0] lo;
    logic [32:0] hi;
    n = (m_count > RANGE_SLOTS) ? RANGE_SLOTS : int'(m_count);
    for (int s = 0; s < n; s++) begin
      if (zr_ign[s] && !m_ign_en) continue;
      lo = {1'b0, zr_first[s]};
      hi = lo + {1'b0, zr_len[s]};
      if ({1'b0, p} >= lo && {1'b0, p} < hi) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void crc_model_step(input req_t r);
    logic [7:0] b;
    crc_res_t   res;
    if (r.kind == KIND_LOAD) begin
      zr_first[r.slot] = r.first;
      zr_len[r.slot]   = r.len;
      zr_ign[r.slot]   = r.ign;
    end else begin
      b = pos_zeroed(file_pos) ? 8'h00 : r.data;
      crc_acc  = crc32_feed(crc_acc, b);
      file_pos = file_pos + 1;
      if (r.last) begin
        res.crc   = ~crc_acc;
        res.match = (res.crc == m_expected);
        pending_crcs.push_back(res);
        last_crc  = res.crc;
        file_pos  = '0;
        crc_acc   = '1;
      end
    end
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.kind  = KIND_DATA;
    r.slot  = SLOT_W'($urandom_range(0, RANGE_SLOTS - 1));
    r.first = $urandom;
    r.len   = $urandom;
    r.ign   = 1'($urandom_range(0, 1));
    r.data  = 8'($urandom);
    r.last  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic int file_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
  endfunction

  task automatic push_load(input int slot, input logic [31:0] first, input logic [31:0] len,
                           input logic ign);
    req_t r;
    r = random_req();
    r.kind  = KIND_LOAD;
    r.slot  = SLOT_W'(slot);
    r.first = first;
    r.len   = len;
    r.ign   = ign;
    req_queue.push_back(r);
    slot_written[slot] = 1'b1;
  endtask

  task automatic rand_load(input int slot);
    logic [31:0] f;
    logic [31:0] l;
    case ($urandom_range(0, 9))
      0: begin
        f = $urandom;
        l = $urandom;
      end
      1: begin
        // end lies past 2^32
        f = 32'hFFFF_FFFF - $urandom_range(0, 40);
        l = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end
      2: begin
        f = $urandom_range(20, 60);
        l = 32'hFFFF_FFFF;
      end
      3: begin
        f = $urandom_range(0, 60);
        l = '0;
      end
      default: begin
        f = $urandom_range(0, 40);
        l = $urandom_range(1, 12);
      end
    endcase
    push_load(slot, f, l, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_bytes(input bit mix);
    req_t r;
    for (int i = 0; i < last_file.size(); i++) begin
      if (mix && $urandom_range(0, 11) == 0) rand_load($urandom_range(0, 31));
      r = random_req();
      r.kind = KIND_DATA;
      r.data = last_file[i];
      r.last = (i == last_file.size() - 1);
      req_queue.push_back(r);
    end
  endtask

  task automatic push_file(input int n, input bit mix);
    logic [7:0] b;
    last_file.delete();
    repeat (n) begin
      b = 8'($urandom);
      case ($urandom_range(0, 9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: ;
      endcase
      last_file.push_back(b);
    end
    send_bytes(mix);
  endtask

  task automatic settle();
    while (req_queue.size() != 0 || in_valid || pending_crcs.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_EXPECTED: m_expected = val;
      REG_COUNT:    m_count = val[CNT_W-1:0];
      REG_IGN_EN:   m_ign_en = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // one setting of the registers, a run of files, then a repeat of the last file
  // against its own CRC so that the match flag is seen set
  task automatic run_phase(input int cnt, input bit heavy);
    int n_files;
    repeat ($urandom_range(2, 6)) rand_load($urandom_range(0, 15));
    if ($urandom_range(0, 2) == 0) rand_load($urandom_range(0, RANGE_SLOTS - 1));
    for (int s = 0; s < cnt && s < RANGE_SLOTS; s++) begin
      if (!slot_written[s]) rand_load(s);
    end
    settle();
    write_reg(REG_COUNT, 32'(cnt));
    write_reg(REG_IGN_EN, 32'($urandom_range(0, 1)));
    write_reg(REG_EXPECTED, $urandom);
    if (heavy) begin
      hold_orders++;
      push_file(4, 1'b0);
      push_file(4, 1'b0);
      // full table reload queued behind two short files
      for (int s = 0; s < RANGE_SLOTS; s++) begin
        if ($urandom_range(0, 15) == 0) rand_load(s);
        else push_load(s, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
    end
    n_files = heavy ? 1 : $urandom_range(1, 3);
    repeat (n_files) push_file(file_len(), 1'b1);
    push_file(file_len(), 1'b0);
    settle();
    write_reg(REG_EXPECTED, last_crc);
    send_bytes(1'b0);
  endtask

  // request driver
  always @(negedge clk) begin : drive_proc
    req_t r;
    if (!in_valid || n_accepted == n_offered) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 4);
      end else if (rst_n && req_queue.size() != 0) begin
        r = req_queue.pop_front();
        in_kind            <= r.kind;
        in_slot            <= r.slot;
        in_range_first     <= r.first;
        in_range_bytes     <= r.len;
        in_range_is_ignore <= r.ign;
        in_data_byte       <= r.data;
        in_last_byte       <= r.last;
        in_valid           <= 1'b1;
        n_offered          <= n_offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side stall
  always @(negedge clk) begin
    if (hold_served != hold_orders) begin
      hold_served <= hold_orders;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_gap != 0) begin
      stall_gap <= stall_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_gap <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // accepted requests feed the predictor; accepted results are checked
  always @(posedge clk) begin : check_proc
    req_t     got;
    crc_res_t want;
    if (rst_n && in_valid && !in_stall) begin
      got.kind  = kind_t'(in_kind);
      got.slot  = in_slot;
      got.first = in_range_first;
      got.len   = in_range_bytes;
      got.ign   = in_range_is_ignore;
      got.data  = in_data_byte;
      got.last  = in_last_byte;
      crc_model_step(got);
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_crcs.size() == 0) begin
        $display("%0t: unexpected result, expected none, got crc_value=%h crc_matches=%b",
                 $time, out_crc_value, out_crc_matches);
        err_count++;
      end else begin
        want = pending_crcs.pop_front();
        if (out_crc_value !== want.crc) begin
          $display("%0t: crc_value expected %h got %h", $time, want.crc, out_crc_value);
          err_count++;
        end
        if (out_crc_matches !== want.match) begin
          $display("%0t: crc_matches expected %b got %b", $time, want.match,
                   out_crc_matches);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 300000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    for (int s = 0; s < RANGE_SLOTS; s++) begin
      zr_first[s] = '0;
      zr_len[s]   = '0;
      zr_ign[s]   = 1'b0;
    end
    file_pos   = '0;
    crc_acc    = '1;
    m_expected = '0;
    m_count    = '0;
    m_ign_en   = 1'b1;
    last_crc   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // standard check string, must match
    last_file = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    write_reg(REG_EXPECTED, 32'hCBF4_3926);
    send_bytes(1'b0);

    // overlapping retain/ignore ranges, empty range, no-wrap end, top slot
    push_load(0, 32'd2, 32'd3, 1'b0);
    push_load(1, 32'd4, 32'd3, 1'b1);
    push_load(2, 32'd0, 32'd0, 1'b0);
    push_load(3, 32'hFFFF_FFF0, 32'h20, 1'b0);
    push_load(RANGE_SLOTS - 1, 32'd0, 32'hFFFF_FFFF, 1'b1);
    settle();
    write_reg(REG_COUNT, 32'd4);
    write_reg(REG_EXPECTED, 32'hFFFF_FFFF);
    last_file.delete();
    repeat (8) last_file.push_back(8'hFF);
    send_bytes(1'b0);
    settle();
    write_reg(REG_IGN_EN, 32'd0);
    send_bytes(1'b0);
    settle();
    write_reg(REG_IGN_EN, 32'd1);

    // result side held off long enough to back up the whole chain
    run_phase(8, 1'b1);
    run_phase(0, 1'b0);
    run_phase(1, 1'b0);

    // full table, then a count past the table size
    run_phase(RANGE_SLOTS, 1'b0);
    run_phase((1 << CNT_W) - 1, 1'b0);

    calm = 1'b1;
    run_phase($urandom_range(2, 16), 1'b0);
    settle();

    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rmc_pkg.sv
hdl/rmc_cell.sv
hdl/rmc_crc.sv
hdl/range_masked_crc32.sv
hdl/rmc_check.sv
sim/tb_range_masked_crc32.sv
